[rtl/core/spp_pkg.sv]
`default_nettype none

package spp_pkg;

    // buffer geometry
    localparam int HIGH_CAPACITY = 32;
    localparam int CNT_W = $clog2(HIGH_CAPACITY + 1);
    localparam int IDX_W = (HIGH_CAPACITY > 1) ? $clog2(HIGH_CAPACITY) : 1;

    // element and register widths
    localparam int WORD_W  = 32;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_PIVOT = 1'b0;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [PADDR_W-1:0] t_paddr;
    typedef logic [PDATA_W-1:0] t_pdata;

    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

endpackage

`default_nettype wire

[rtl/core/stable_partition_by_pivot_top.sv]
// stable partition of signed 32-bit words around a programmable pivot
// input channel: i_in_valid / o_in_ready with i_value and i_last_in
// output channel: o_out_valid / i_out_ready with o_out_value, o_above_pivot,
//   o_last_out and o_overflow
// pivot is written over the APB port at byte address 0 (pready always high)
// an element at or below the pivot shows up on the output the cycle after it
//   is taken; a greater element goes into a 32-entry buffer ram instead
// while a sequence streams in, one element is taken per cycle as long as the
//   output register is empty or being emptied in the same cycle
// the element marked last starts the drain when the sequence held a greater
//   element: buffered elements come out in arrival order, each in turn (the
//   ram address is set, then its registered read data is moved to the output
//   register); no input during drain
// greater elements beyond 32 are dropped; if any is dropped, o_overflow is set
//   on the result that carries o_last_out
// a stalled receiver simply holds the output register and the drain pauses
// reset (synchronous, active low) clears the pivot, buffer count, drop flag
//   and output valid; buffer contents need no clearing
`default_nettype none

module stable_partition_by_pivot_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // element request in
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire spp_pkg::t_word   i_value,
    input  wire logic             i_last_in,
    // result request out
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output spp_pkg::t_word        o_out_value,
    output logic                  o_above_pivot,
    output logic                  o_last_out,
    output logic                  o_overflow,
    // configuration
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire spp_pkg::t_paddr  paddr,
    input  wire spp_pkg::t_pdata  pwdata,
    output spp_pkg::t_pdata       prdata,
    output logic                  pready
);

    import spp_pkg::*;

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;      // buffered greater elements
    logic               r_dropped, n_dropped;  // a greater element did not fit
    logic [CNT_W-1:0]   r_rd_ptr, n_rd_ptr;    // drain position
    logic               r_rd_ok, n_rd_ok;      // ram data valid for r_rd_ptr
    t_word              r_pivot;

    // output register
    logic               r_out_valid, n_out_valid;
    t_word              r_out_value, n_out_value;
    logic               r_out_above, n_out_above;
    logic               r_out_last, n_out_last;
    logic               r_out_ovf, n_out_ovf;

    logic               w_slot_free;
    logic               w_accept;
    logic               w_above;
    logic               w_room;
    logic               w_wr_en;
    logic               w_load;
    logic               w_fin;
    logic               w_cfg_wr;
    t_word              w_rd_data;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot <= '0;
        end else if (w_cfg_wr && (paddr[2] == REG_PIVOT)) begin
            r_pivot <= t_word'(pwdata);
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PIVOT: prdata = t_pdata'(r_pivot);
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // intake: one signed compare, at most one buffer write
    // ---------------------------------------------------------------
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_RUN) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_above     = i_value > r_pivot;
    assign w_room      = r_count < CNT_W'(HIGH_CAPACITY);
    assign w_wr_en     = w_accept && w_above && w_room;
    // last buffered element reached during drain
    assign w_fin       = (r_rd_ptr + CNT_W'(1)) == r_count;

    // greater-element buffer; write slot is the current count, drain reads
    // by pointer, never in the same cycle as a write to that entry
    spp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HIGH_CAPACITY)
    ) u_high_buf (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_rd_ptr[IDX_W-1:0]),
        .o_rdata (w_rd_data)
    );

    // ---------------------------------------------------------------
    // sequencing
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_rd_ptr    = r_rd_ptr;
        n_rd_ok     = 1'b0;
        w_load      = 1'b0;
        n_out_value = r_out_value;
        n_out_above = r_out_above;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            S_RUN: begin
                if (w_accept) begin
                    if (w_above) begin
                        if (w_room) begin
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end else begin
                        // pass straight through; final only if nothing buffered
                        w_load      = 1'b1;
                        n_out_value = i_value;
                        n_out_above = 1'b0;
                        n_out_last  = i_last_in && (r_count == '0);
                        n_out_ovf   = i_last_in && (r_count == '0) && r_dropped;
                    end
                    if (i_last_in) begin
                        if (w_above || (r_count != '0)) begin
                            n_state  = S_DRAIN;
                            n_rd_ptr = '0;
                        end else begin
                            n_count   = '0;
                            n_dropped = 1'b0;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (r_rd_ok && w_slot_free) begin
                    w_load      = 1'b1;
                    n_out_value = w_rd_data;
                    n_out_above = 1'b1;
                    n_out_last  = w_fin;
                    n_out_ovf   = w_fin && r_dropped;
                    if (w_fin) begin
                        n_state   = S_RUN;
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_rd_ptr  = '0;
                    end else begin
                        n_rd_ptr = r_rd_ptr + CNT_W'(1);
                    end
                end else begin
                    // address held; read data is good from next cycle on
                    n_rd_ok = 1'b1;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase

        n_out_valid = w_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_rd_ptr    <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_rd_ptr    <= n_rd_ptr;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= n_out_value;
            r_out_above <= n_out_above;
            r_out_last  <= n_out_last;
            r_out_ovf   <= n_out_ovf;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_above_pivot = r_out_above;
    assign o_last_out    = r_out_last;
    assign o_overflow    = r_out_ovf;

`ifndef SYNTH
    // buffer count stays within capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HIGH_CAPACITY))
        else $error("buffer count above capacity");

    // drain pointer only walks over filled entries
    a_drain_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_rd_ptr < r_count))
        else $error("drain pointer past buffer fill");

    // no element is taken while the buffer drains
    a_no_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !o_in_ready)
        else $error("input taken during drain");

    // end of drain leaves an empty buffer and a final result
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DRAIN) && (n_state == S_RUN))
            |=> ((r_count == '0) && !r_dropped && r_out_valid && r_out_last))
        else $error("drain end did not close the sequence");

    // overflow is reported only on the final result
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> o_last_out)
        else $error("overflow on a non-final result");
`endif

endmodule

`default_nettype wire

[rtl/core/spp_ram.sv]
`default_nettype none

module spp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd_data;

endmodule

`default_nettype wire

[sim/spp_partition_checker.sv]
module spp_partition_checker (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_elem_valid,
    input  wire logic            i_elem_ready,
    input  wire spp_pkg::t_word  i_elem_value,
    input  wire logic            i_elem_last,
    input  wire logic            i_res_valid,
    input  wire logic            i_res_ready,
    input  wire spp_pkg::t_word  i_res_value,
    input  wire logic            i_res_above,
    input  wire logic            i_res_last,
    input  wire logic            i_res_overflow,
    input  wire logic            i_psel,
    input  wire logic            i_penable,
    input  wire logic            i_pwrite,
    input  wire logic            i_pready,
    input  wire spp_pkg::t_paddr i_paddr,
    input  wire spp_pkg::t_pdata i_pwdata,
    output int                   o_mismatch_count,
    output int                   o_results_owed
);

    import spp_pkg::*;

    typedef struct packed {
        t_word value;
        logic  above;
        logic  last;
        logic  overflow;
    } t_part_result;

    localparam int REPORT_LIMIT = 10;

    t_word        pivot;
    t_word        high_held[$];
    logic         high_dropped;
    t_part_result owed[$];
    t_part_result seen;
    t_part_result wanted;
    int           mismatches = 0;

    function automatic t_part_result make_result(t_word v, logic a, logic l, logic o);
        t_part_result r;
        r.value    = v;
        r.above    = a;
        r.last     = l;
        r.overflow = o;
        return r;
    endfunction

    function automatic string show_result(t_part_result r);
        return $sformatf("value=%0d above=%0b last=%0b ovf=%0b",
                         r.value, r.above, r.last, r.overflow);
    endfunction

    // one element in, zero or more partitioned results owed
    task automatic partition_element(t_word v, logic last);
        logic above;
        logic fin;
        int   n;
        above = v > pivot;
        if (above) begin
            if (high_held.size() < HIGH_CAPACITY)
                high_held.push_back(v);
            else
                high_dropped = 1'b1;
        end
        if (!last) begin
            if (!above)
                owed.push_back(make_result(v, 1'b0, 1'b0, 1'b0));
        end else begin
            n = high_held.size();
            if (!above) begin
                fin = (n == 0);
                owed.push_back(make_result(v, 1'b0, fin, fin & high_dropped));
            end
            for (int i = 0; i < n; i++) begin
                fin = (i == n - 1);
                owed.push_back(make_result(high_held[i], 1'b1, fin, fin & high_dropped));
            end
            high_held.delete();
            high_dropped = 1'b0;
        end
    endtask

    task automatic report_failure(string what, t_part_result e, t_part_result g);
        string exp_s;
        string got_s;
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            exp_s = show_result(e);
            got_s = show_result(g);
            $display("%s: expected %s, got %s", what, exp_s, got_s);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pivot        = '0;
            high_dropped = 1'b0;
            high_held.delete();
            owed.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_PIVOT)
                pivot = i_pwdata;
            if (i_elem_valid && i_elem_ready)
                partition_element(i_elem_value, i_elem_last);
            if (i_res_valid && i_res_ready) begin
                seen = make_result(i_res_value, i_res_above, i_res_last, i_res_overflow);
                if (owed.size() == 0) begin
                    report_failure("unexpected result", seen, seen);
                end else begin
                    wanted = owed.pop_front();
                    if (seen.value !== wanted.value || seen.above !== wanted.above ||
                        seen.last !== wanted.last || seen.overflow !== wanted.overflow)
                        report_failure("result mismatch", wanted, seen);
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_results_owed   <= owed.size();
    end

endmodule

[sim/stable_partition_by_pivot_top_tb.sv]
module stable_partition_by_pivot_top_tb;
    import spp_pkg::*;

    // run limits and pacing
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     HOLD_CYCLES   = 150;
    localparam int     SETTLE_CYCLES = 4;
    // tail wait, sized from the buffer capacity to cover a full drain
    localparam int     TAIL_CYCLES   = 2 * HIGH_CAPACITY + 8;
    localparam int     PHASE_ITEMS   = 50;

    // register map: pivot at index 0, index 1 is unmapped and must be ignored
    localparam t_paddr ADDR_PIVOT = {REG_PIVOT, 2'b00};
    localparam t_paddr ADDR_SPARE = {~REG_PIVOT, 2'b00};

    localparam t_word  WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word  WORD_MIN = 32'sh8000_0000;

    logic   clk;
    logic   rst_n       = 1'b0;

    // element requests toward the block
    logic   elem_valid  = 1'b0;
    logic   elem_ready;
    t_word  elem_value  = '0;
    logic   elem_last   = 1'b0;

    // result requests from the block
    logic   res_valid;
    logic   res_ready   = 1'b0;
    t_word  res_value;
    logic   res_above;
    logic   res_last;
    logic   res_overflow;

    // configuration port
    logic   psel        = 1'b0;
    logic   penable     = 1'b0;
    logic   pwrite      = 1'b0;
    t_paddr paddr       = '0;
    t_pdata pwdata      = '0;
    t_pdata prdata;
    logic   pready;

    // pacing knobs, percent of cycles spent idle
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    // receiver hold-off handshake between stimulus and receiver process
    int     hold_requests = 0;
    int     hold_seen     = 0;
    int     hold_left     = 0;

    int     items_sent    = 0;
    int     cycle_count   = 0;
    int     mismatch_count;
    int     results_owed;

    // pivot as last written, used only to shape the stimulus
    t_word  pivot_now     = '0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    stable_partition_by_pivot_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (elem_valid),
        .o_in_ready    (elem_ready),
        .i_value       (elem_value),
        .i_last_in     (elem_last),
        .o_out_valid   (res_valid),
        .i_out_ready   (res_ready),
        .o_out_value   (res_value),
        .o_above_pivot (res_above),
        .o_last_out    (res_last),
        .o_overflow    (res_overflow),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // watches both channels and the config port, predicts and compares
    spp_partition_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_elem_valid     (elem_valid),
        .i_elem_ready     (elem_ready),
        .i_elem_value     (elem_value),
        .i_elem_last      (elem_last),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_res_value      (res_value),
        .i_res_above      (res_above),
        .i_res_last       (res_last),
        .i_res_overflow   (res_overflow),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_mismatch_count (mismatch_count),
        .o_results_owed   (results_owed)
    );

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL stable_partition_by_pivot_top");
            $finish;
        end
    end

    // receiver: random back-pressure, or a long hold-off when asked for one
    always @(posedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one element; valid stays up across back-to-back requests and only
    // drops during an idle gap, so it never gets two updates in one step
    task automatic send_elem(t_word v, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            elem_valid <= 1'b0;
            @(posedge clk);
        end
        elem_valid <= 1'b1;
        elem_value <= v;
        elem_last  <= last;
        @(posedge clk);
        while (!elem_ready) @(posedge clk);
        items_sent++;
    endtask

    // stop offering and let every owed result come out, plus a short settle
    // the first edge lets the owed count catch up with the last request
    task automatic wait_drained();
        elem_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup then access, only ever with the block idle
    task automatic write_reg(t_paddr a, t_pdata d);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_pivot(t_word p);
        write_reg(ADDR_PIVOT, p);
        pivot_now = p;
    endtask

    // element values: mostly full random, some hugging the pivot, some extremes
    function automatic t_word pick_value();
        logic signed [33:0] wide;
        int                 delta;
        t_word              v;
        v = t_word'($urandom);
        case ($urandom_range(3))
            0: begin
                delta = int'($urandom_range(6)) - 3;
                wide  = pivot_now;
                wide  = wide + delta;
                if (wide > WORD_MAX)
                    v = WORD_MAX;
                else if (wide < WORD_MIN)
                    v = WORD_MIN;
                else
                    v = wide[31:0];
            end
            1: begin
                case ($urandom_range(3))
                    0:       v = WORD_MAX;
                    1:       v = WORD_MIN;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_word pick_pivot();
        case ($urandom_range(7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return t_word'(int'($urandom_range(200)) - 100);
            3:       return '0;
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic run_sequence(int len);
        for (int k = 1; k <= len; k++)
            send_elem(pick_value(), k == len);
    endtask

    // with the pivot at the minimum, any odd value lands in the buffer
    task automatic send_above_run(int n);
        for (int k = 0; k < n; k++)
            send_elem(t_word'($urandom | 1), 1'b0);
    endtask

    initial begin
        int phase;
        int goal;
        int len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pivot still at its reset value of zero
        // equal to pivot stays low, extremes on both sides, last one low
        send_elem('0, 1'b0);
        send_elem(t_word'(1), 1'b0);
        send_elem(WORD_MIN, 1'b0);
        send_elem(WORD_MAX, 1'b0);
        send_elem('1, 1'b0);
        send_elem(t_word'(32'h5555_5555), 1'b0);
        send_elem(t_word'(-5), 1'b1);
        // single low element with an empty buffer ends the sequence itself
        send_elem(t_word'(-7), 1'b1);
        // single greater element: joins the buffer and drains at once
        send_elem(t_word'(9), 1'b1);

        // pivot at the top: nothing can be above it
        write_pivot(WORD_MAX);
        send_elem(t_word'(32'hAAAA_AAAA), 1'b0);
        send_elem(WORD_MAX, 1'b1);

        // pivot at the bottom: everything but the minimum is above
        write_pivot(WORD_MIN);
        send_elem(WORD_MIN, 1'b0);
        send_elem('0, 1'b0);
        send_elem(WORD_MIN, 1'b1);

        // write to the unmapped index, pivot must stay at the minimum
        write_reg(ADDR_SPARE, t_pdata'($urandom));
        send_elem(t_word'(3), 1'b0);
        send_elem(t_word'(-3), 1'b1);

        write_pivot('1);
        send_elem('0, 1'b0);
        send_elem('1, 1'b1);

        // random part in three pacing phases
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                write_pivot(WORD_MIN);
                // exactly full buffer, low last: longest drain, no overflow
                send_above_run(HIGH_CAPACITY);
                send_elem(WORD_MIN, 1'b1);
                // full buffer, greater last gets dropped: overflow on last result
                send_above_run(HIGH_CAPACITY);
                send_elem(t_word'($urandom | 1), 1'b1);
                // one past full, low last comes out first without the last mark
                send_above_run(HIGH_CAPACITY + 1);
                send_elem(WORD_MIN, 1'b1);
            end

            if (phase == 2) begin
                // receiver holds off while requests keep coming, so the
                // output register fills and the block stalls its input
                hold_requests++;
                run_sequence(20);
            end

            write_pivot(pick_pivot());
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(11, HIGH_CAPACITY + 8);
                else
                    len = $urandom_range(1, 8);
                run_sequence(len);
                if ($urandom_range(3) == 0)
                    write_pivot(pick_pivot());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_owed == 0)
            $display("PASS stable_partition_by_pivot_top");
        else
            $display("FAIL stable_partition_by_pivot_top");
        $finish;
    end

endmodule
